/* sv/spe_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// spe_pkg
// Shared types, constants and the divider step for the starfield engine.
// ============================================================================
package spe_pkg;

    // Field widths
    localparam int IDX_W    = 7;
    localparam int COORD_W  = 8;
    localparam int DEPTH_W  = 7;
    localparam int PIX_W    = 8;
    localparam int SCALE_W  = 8;
    localparam int SHADE_W  = 4;
    localparam int PROD_W   = COORD_W + SCALE_W;

    // Divider shape: quotient bits resolved per stage, number of stages
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = 5;
    localparam int QUO_W      = DIV_STEPS * DIV_STAGES;

    // Items in flight: two front stages, the divider stages, the output register
    localparam int PIPE_CAP = DIV_STAGES + 3;

    // Shade mapping
    localparam logic [SHADE_W-1:0] SHADE_TOP   = 4'd15;
    localparam logic [SHADE_W-1:0] SHADE_FLOOR = 4'd8;
    localparam int                 SHADE_SHIFT = 3;

    // Register reset values
    localparam logic [PIX_W-1:0]    RST_SCREEN_WIDTH  = 8'd160;
    localparam logic [PIX_W-1:0]    RST_SCREEN_HEIGHT = 8'd102;
    localparam logic [SCALE_W-1:0]  RST_FOCAL_SCALE   = 8'd50;
    localparam logic [DEPTH_W-1:0]  RST_FAR_DEPTH     = 7'd64;

    typedef enum logic {
        OP_INIT    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_FOCAL_SCALE   = 2'd2,
        REG_FAR_DEPTH     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_opcode                    opcode;
        logic [IDX_W-1:0]           star_index;
        logic signed [COORD_W-1:0]  new_x;
        logic signed [COORD_W-1:0]  new_y;
        logic [DEPTH_W-1:0]         new_depth;
    } t_item;

    typedef struct packed {
        logic                   pixel_valid;
        logic [PIX_W-1:0]       pixel_x;
        logic [PIX_W-1:0]       pixel_y;
        logic [SHADE_W-1:0]     shade;
        logic                   star_recycled;
    } t_res;

    typedef struct packed {
        logic [PIX_W-1:0]    screen_width;
        logic [PIX_W-1:0]    screen_height;
        logic [SCALE_W-1:0]  focal_scale;
        logic [DEPTH_W-1:0]  far_depth;
    } t_cfg;

    // Per-item control that travels beside the divider lanes
    typedef struct packed {
        t_opcode             op;
        logic                wr;
        logic [IDX_W-1:0]    index;
        logic [COORD_W-1:0]  new_x;
        logic [COORD_W-1:0]  new_y;
        logic [DEPTH_W-1:0]  new_depth;
        logic [DEPTH_W-1:0]  zd;
        logic                zero;
        logic                sx;
        logic                sy;
    } t_side;

    // One divider lane: dividend bits shift out at the top, quotient bits in
    typedef struct packed {
        logic [QUO_W-1:0]   work;
        logic [DEPTH_W-1:0] rem;
    } t_dlane;

    // Store write-back request
    typedef struct packed {
        logic                we_xy;
        logic                we_z;
        logic [IDX_W-1:0]    index;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [DEPTH_W-1:0]  depth;
    } t_wr;

    // Resolve DIV_STEPS quotient bits of a restoring division
    function automatic t_dlane div_steps(input t_dlane d, input logic [DEPTH_W-1:0] z);
        t_dlane           r;
        logic [DEPTH_W:0] trial;
        r = d;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {r.rem, r.work[QUO_W-1]};
            if (trial >= {1'b0, z}) begin
                r.rem  = DEPTH_W'(trial - {1'b0, z});
                r.work = {r.work[QUO_W-2:0], 1'b1};
            end else begin
                r.rem  = trial[DEPTH_W-1:0];
                r.work = {r.work[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* sv/spe_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// spe_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module spe_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/spe_div_pipe.sv */
`timescale 1ns / 1ps
// ============================================================================
// spe_div_pipe
// Pipelined restoring divider, two lanes (x and y) sharing one divisor.
// ============================================================================
module spe_div_pipe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  spe_pkg::t_side          i_side,
    input  spe_pkg::t_dlane         i_lx,
    input  spe_pkg::t_dlane         i_ly,
    input  logic [spe_pkg::IDX_W-1:0] i_probe,
    output logic                    o_hit,
    output logic                    o_valid,
    input  logic                    i_ready,
    output spe_pkg::t_side          o_side,
    output logic [spe_pkg::QUO_W-1:0] o_qx,
    output logic [spe_pkg::QUO_W-1:0] o_qy
);
    import spe_pkg::*;

    logic   r_v    [DIV_STAGES];
    t_side  r_side [DIV_STAGES];
    t_dlane r_lx   [DIV_STAGES];
    t_dlane r_ly   [DIV_STAGES];

    logic   en     [DIV_STAGES];
    logic   src_v  [DIV_STAGES];
    t_side  src_s  [DIV_STAGES];
    t_dlane src_x  [DIV_STAGES];
    t_dlane src_y  [DIV_STAGES];

    // Stage enables: a stage loads when empty or when its beat moves on
    always_comb begin
        en[DIV_STAGES-1] = !r_v[DIV_STAGES-1] || i_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // Stage sources
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                src_v[k] = i_valid;
                src_s[k] = i_side;
                src_x[k] = div_steps(i_lx, i_side.zd);
                src_y[k] = div_steps(i_ly, i_side.zd);
            end else begin
                src_v[k] = r_v[k-1];
                src_s[k] = r_side[k-1];
                src_x[k] = div_steps(r_lx[k-1], r_side[k-1].zd);
                src_y[k] = div_steps(r_ly[k-1], r_side[k-1].zd);
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= src_v[k];
                end
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k]) begin
                r_side[k] <= src_s[k];
                r_lx[k]   <= src_x[k];
                r_ly[k]   <= src_y[k];
            end
        end
    end

    // Flag a pending store write to the probed star
    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (r_v[k] && r_side[k].wr && (r_side[k].index == i_probe)) begin
                o_hit = 1'b1;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_qx    = r_lx[DIV_STAGES-1].work;
    assign o_qy    = r_ly[DIV_STAGES-1].work;

endmodule

/* sv/spe_project.sv */
`timescale 1ns / 1ps
// ============================================================================
// spe_project
// Final stage: sign and center the quotients, test the screen bounds,
// pick the shade, issue the store write-back and hold the result beat.
// ============================================================================
module spe_project (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  spe_pkg::t_side             i_side,
    input  logic [spe_pkg::QUO_W-1:0]  i_qx,
    input  logic [spe_pkg::QUO_W-1:0]  i_qy,
    input  spe_pkg::t_cfg              i_cfg,
    output spe_pkg::t_wr               o_wr,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output spe_pkg::t_res              o_res
);
    import spe_pkg::*;

    localparam int PW  = QUO_W + 2;
    localparam int SHW = DEPTH_W - SHADE_SHIFT;

    logic                    r_valid;
    t_res                    r_res;
    t_res                    n_res;

    logic signed [PW-1:0]    qx_s;
    logic signed [PW-1:0]    qy_s;
    logic signed [PW-1:0]    px_s;
    logic signed [PW-1:0]    py_s;
    logic signed [PW-1:0]    w_s;
    logic signed [PW-1:0]    h_s;
    logic                    off;
    logic                    recycle;
    logic [SHW-1:0]          sh;
    logic [SHADE_W-1:0]      shade;
    logic                    fire;

    assign o_ready = !r_valid || i_res_ready;
    assign fire    = i_valid && o_ready && i_side.wr;

    // Project and test bounds
    always_comb begin
        qx_s = $signed({2'b00, i_qx});
        qy_s = $signed({2'b00, i_qy});
        if (i_side.sx) begin
            qx_s = -qx_s;
        end
        if (i_side.sy) begin
            qy_s = -qy_s;
        end
        w_s  = $signed({{(PW-PIX_W){1'b0}}, i_cfg.screen_width});
        h_s  = $signed({{(PW-PIX_W){1'b0}}, i_cfg.screen_height});
        px_s = qx_s + $signed({{(PW-PIX_W+1){1'b0}}, i_cfg.screen_width[PIX_W-1:1]});
        py_s = qy_s + $signed({{(PW-PIX_W+1){1'b0}}, i_cfg.screen_height[PIX_W-1:1]});
        off  = (px_s < 0) || (px_s >= w_s) || (py_s < 0) || (py_s >= h_s);
        recycle = i_side.zero || off;
    end

    // Shade: brighter when nearer, floored
    always_comb begin
        sh = i_side.zd[DEPTH_W-1:SHADE_SHIFT];
        if (SHADE_W'(sh) > (SHADE_TOP - SHADE_FLOOR)) begin
            shade = SHADE_FLOOR;
        end else begin
            shade = SHADE_TOP - SHADE_W'(sh);
        end
    end

    // Result and write-back
    always_comb begin
        n_res          = '0;
        n_res.shade    = SHADE_FLOOR;
        o_wr.we_xy     = 1'b0;
        o_wr.we_z      = 1'b0;
        o_wr.index     = i_side.index;
        o_wr.x         = i_side.new_x;
        o_wr.y         = i_side.new_y;
        o_wr.depth     = i_side.new_depth;
        if (i_side.wr) begin
            if (i_side.op == OP_INIT) begin
                o_wr.we_xy = fire;
                o_wr.we_z  = fire;
            end else if (recycle) begin
                o_wr.we_xy          = fire;
                o_wr.we_z           = fire;
                o_wr.depth          = i_cfg.far_depth;
                n_res.star_recycled = 1'b1;
            end else begin
                o_wr.we_z         = fire;
                o_wr.depth        = i_side.zd;
                n_res.pixel_valid = 1'b1;
                n_res.pixel_x     = px_s[PIX_W-1:0];
                n_res.pixel_y     = py_s[PIX_W-1:0];
                n_res.shade       = shade;
            end
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

/* sv/starfield_projection_engine_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// starfield_projection_engine_top
// Perspective starfield: per-star store, depth step, projection through a
// pipelined divider, bounds test and recycle to the far plane.
// ============================================================================
//
//  Channel   Direction  Handshake                     Beat
//  item      in         i_item_valid / o_item_ready   spe_pkg::t_item
//  result    out        o_res_valid  / i_res_ready    spe_pkg::t_res
//  config    in         psel/penable/pwrite/pready    4 regs at byte 0,4,8,12
//
//  One item enters per cycle unless a result stall or a hazard holds it.
//  The read register loads at the accepting edge, then the item passes the
//  multiply stage, 5 divider stages of 3 quotient bits each and the output
//  register. An item for a star still in flight waits until that star has
//  written back; the single store write port at the last stage sets this.
//  Reset is synchronous; it clears valid bits and loads the register defaults.
//  Star stores are not cleared. A stall on the result side backs up stage by
//  stage and fills bubbles first.
//
module starfield_projection_engine_top #(
    parameter int STAR_COUNT = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  spe_pkg::t_item  i_item,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output spe_pkg::t_res   o_res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import spe_pkg::*;

    localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

    // Configuration registers
    t_cfg                r_cfg;

    // Stage A: store read
    logic                r_a_valid;
    t_item               r_a_item;
    logic                r_a_wr;

    // Stage M: products into the divider
    logic                r_m_valid;
    t_side               r_m_side;
    t_dlane              r_m_lx;
    t_dlane              r_m_ly;
    t_side               n_m_side;
    t_dlane              n_m_lx;
    t_dlane              n_m_ly;

    logic                en_a;
    logic                en_m;
    logic                accept;
    logic                hazard;
    logic                in_range;
    logic                div_ready;
    logic                div_hit;
    logic                div_valid;
    t_side               div_side;
    logic [QUO_W-1:0]    div_qx;
    logic [QUO_W-1:0]    div_qy;
    logic                prj_ready;
    t_wr                 wr;

    logic [AW+IDX_W-1:0] raddr_ext;
    logic [AW+IDX_W-1:0] waddr_ext;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic [COORD_W-1:0]  rd_x;
    logic [COORD_W-1:0]  rd_y;
    logic [DEPTH_W-1:0]  rd_z;
    logic [COORD_W-1:0]  ax;
    logic [COORD_W-1:0]  ay;
    logic [PROD_W-1:0]   prod_x;
    logic [PROD_W-1:0]   prod_y;
    logic [DEPTH_W-1:0]  zd;

    // Configuration port: writes and reads
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.focal_scale   <= RST_FOCAL_SCALE;
            r_cfg.far_depth     <= RST_FAR_DEPTH;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[PIX_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[PIX_W-1:0];
                REG_FOCAL_SCALE:   r_cfg.focal_scale   <= pwdata[SCALE_W-1:0];
                REG_FAR_DEPTH:     r_cfg.far_depth     <= pwdata[DEPTH_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_SCREEN_WIDTH:  prdata = 32'(r_cfg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(r_cfg.screen_height);
            REG_FOCAL_SCALE:   prdata = 32'(r_cfg.focal_scale);
            REG_FAR_DEPTH:     prdata = 32'(r_cfg.far_depth);
        endcase
    end

    // Front enables and hazard interlock on pending writes to the same star
    assign en_m     = !r_m_valid || div_ready;
    assign en_a     = !r_a_valid || en_m;
    assign in_range = ({25'd0, i_item.star_index} < 32'(STAR_COUNT));
    assign hazard   = (r_a_valid && r_a_wr && (r_a_item.star_index == i_item.star_index))
                   || (r_m_valid && r_m_side.wr && (r_m_side.index == i_item.star_index))
                   || div_hit;
    assign o_item_ready = en_a && !hazard;
    assign accept       = i_item_valid && o_item_ready;

    // Store addresses
    assign raddr_ext = {{AW{1'b0}}, i_item.star_index};
    assign waddr_ext = {{AW{1'b0}}, wr.index};
    assign raddr     = raddr_ext[AW-1:0];
    assign waddr     = waddr_ext[AW-1:0];

    spe_ram #(.WIDTH(COORD_W), .DEPTH(STAR_COUNT)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (wr.we_xy),
        .i_waddr (waddr),
        .i_wdata (wr.x),
        .i_re    (en_a),
        .i_raddr (raddr),
        .o_rdata (rd_x)
    );

    spe_ram #(.WIDTH(COORD_W), .DEPTH(STAR_COUNT)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (wr.we_xy),
        .i_waddr (waddr),
        .i_wdata (wr.y),
        .i_re    (en_a),
        .i_raddr (raddr),
        .o_rdata (rd_y)
    );

    spe_ram #(.WIDTH(DEPTH_W), .DEPTH(STAR_COUNT)) u_ram_z (
        .i_clk   (i_clk),
        .i_we    (wr.we_z),
        .i_waddr (waddr),
        .i_wdata (wr.depth),
        .i_re    (en_a),
        .i_raddr (raddr),
        .o_rdata (rd_z)
    );

    // Stage A registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_item <= i_item;
            r_a_wr   <= in_range;
        end
    end

    // Step the depth, take magnitudes and scale
    always_comb begin
        zd     = (rd_z != '0) ? (rd_z - DEPTH_W'(1)) : '0;
        ax     = rd_x[COORD_W-1] ? (~rd_x + COORD_W'(1)) : rd_x;
        ay     = rd_y[COORD_W-1] ? (~rd_y + COORD_W'(1)) : rd_y;
        prod_x = PROD_W'(ax) * PROD_W'(r_cfg.focal_scale);
        prod_y = PROD_W'(ay) * PROD_W'(r_cfg.focal_scale);

        n_m_side.op        = r_a_item.opcode;
        n_m_side.wr        = r_a_wr;
        n_m_side.index     = r_a_item.star_index;
        n_m_side.new_x     = r_a_item.new_x;
        n_m_side.new_y     = r_a_item.new_y;
        n_m_side.new_depth = r_a_item.new_depth;
        n_m_side.zd        = zd;
        n_m_side.zero      = (zd == '0);
        n_m_side.sx        = rd_x[COORD_W-1];
        n_m_side.sy        = rd_y[COORD_W-1];

        n_m_lx.work = prod_x[QUO_W-1:0];
        n_m_lx.rem  = '0;
        n_m_ly.work = prod_y[QUO_W-1:0];
        n_m_ly.rem  = '0;
    end

    // Stage M registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en_m) begin
            r_m_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_m_side <= n_m_side;
            r_m_lx   <= n_m_lx;
            r_m_ly   <= n_m_ly;
        end
    end

    spe_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid),
        .o_ready (div_ready),
        .i_side  (r_m_side),
        .i_lx    (r_m_lx),
        .i_ly    (r_m_ly),
        .i_probe (i_item.star_index),
        .o_hit   (div_hit),
        .o_valid (div_valid),
        .i_ready (prj_ready),
        .o_side  (div_side),
        .o_qx    (div_qx),
        .o_qy    (div_qy)
    );

    spe_project u_project (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .o_ready     (prj_ready),
        .i_side      (div_side),
        .i_qx        (div_qx),
        .i_qy        (div_qy),
        .i_cfg       (r_cfg),
        .o_wr        (wr),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

/* sv/spe_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// spe_checker
// Port-level checks on the starfield engine: reset idle, occupancy and result hold.
// ============================================================================
module spe_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  logic            o_item_ready,
    input  logic            o_res_valid,
    input  logic            i_res_ready,
    input  spe_pkg::t_res   o_res
);
    import spe_pkg::*;

    localparam int CW = $clog2(PIPE_CAP + 1);

    logic          in_beat;
    logic          out_beat;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign in_beat  = i_item_valid && o_item_ready;
    assign out_beat = o_res_valid && i_res_ready;

    // Track items accepted but not yet delivered
    always_comb begin
        n_count = r_count;
        if (in_beat && !out_beat) begin
            n_count = r_count + CW'(1);
        end else if (out_beat && !in_beat) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Drop the result beat after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // Deliver no result without an accepted item behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (r_count != '0))
        else $error("result without accepted item");

    // Hold no more items than the pipeline has stages
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PIPE_CAP))
        else $error("items in flight exceed pipeline capacity");

    // Hold a stalled result beat
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("stalled result changed");

endmodule

bind starfield_projection_engine_top spe_checker u_spe_checker (.*);
